// ===== rtl/phi4fe_pkg.sv =====
// Shared constants for the two-field phi^4 free energy site unit.
// Default widths, register indexes and field counts; no dependencies.

package phi4fe_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_REGS       = 7;
  localparam int CFG_INDEX_W    = 3;
  localparam int NUM_IN_FIELDS  = 11;
  localparam int NUM_OUT_FIELDS = 9;
  localparam int NUM_PAIRS      = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHI_BULK_A      = 3'd0,
    REG_PHI_BULK_B      = 3'd1,
    REG_PHI_KAPPA_BASE  = 3'd2,
    REG_PHI_KAPPA_SLOPE = 3'd3,
    REG_PSI_BULK_A      = 3'd4,
    REG_PSI_BULK_B      = 3'd5,
    REG_PSI_KAPPA_GAIN  = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/two_field_phi4_free_energy_site_unit.sv =====
// Two-field symmetric phi^4 free energy, chemical potentials and stress per site.
// Fourteen-stage pipeline of saturating fixed-point products and sums.
// Depends on phi4fe_pkg for defaults and register indexes.
// Throughput: one item per cycle when the output is not stalled; each stage holds
// one item and loads when it is empty or when the stage after it moves, so bubbles
// close up behind a stalled output.
// Reset (rst, synchronous): clears all stage valid flags and the seven
// coefficient registers to zero; payload registers are not reset.

module two_field_phi4_free_energy_site_unit
  import phi4fe_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_wen,
  input  logic [CFG_INDEX_W-1:0]                      cfg_index,
  input  logic [DATA_WIDTH-1:0]                       cfg_data,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // fields from bit 0: phi_value, psi_value, site_temperature, grad_phi_x,
  // grad_phi_y, grad_phi_z, grad_psi_x, grad_psi_y, grad_psi_z,
  // laplacian_phi, laplacian_psi, then zero fill to whole bytes
  input  logic [((NUM_IN_FIELDS*DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // fields from bit 0: energy_density, mu_phi, mu_psi, stress_xx, stress_xy,
  // stress_xz, stress_yy, stress_yz, stress_zz, then zero fill to whole bytes
  output logic [((NUM_OUT_FIELDS*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W      = DATA_WIDTH;
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int OUT_TW = ((NUM_OUT_FIELDS * DATA_WIDTH + 7) / 8) * 8;
  localparam int NSTAGE = 14;

  typedef logic signed [W-1:0]  word_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam word_t       WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t       WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  // gradient component pairs in output order xx, xy, xz, yy, yz, zz
  localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_B [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};

  function automatic prod_t fx_prod(input word_t a, input word_t b);
    prod_t ea, eb;
    ea = prod_t'(a);
    eb = prod_t'(b);
    return ea * eb;
  endfunction

  // round magnitude to nearest, ties away from zero, then saturate
  function automatic word_t fx_round(input prod_t p);
    logic          neg;
    logic [PW-1:0] mag, q;
    word_t         r;
    neg = p[PW-1];
    mag = neg ? unsigned'(-p) : unsigned'(p);
    q   = (mag + RND) >> FRAC_BITS;
    if (q >= LIM) begin
      r = neg ? WMIN : WMAX;
    end else begin
      r = neg ? -word_t'(q[W-1:0]) : word_t'(q[W-1:0]);
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [W:0] s;
    word_t      r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? WMIN : WMAX;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic [W:0] s;
    word_t      r;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? WMIN : WMAX;
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // products by 0.5, 0.25 and 0.75 never overflow: round the magnitude only
  function automatic word_t fx_half(input word_t x);
    logic [W-1:0] mag;
    logic [W:0]   t;
    word_t        q;
    mag = x[W-1] ? unsigned'(-x) : unsigned'(x);
    t   = {1'b0, mag} + (W+1)'(1);
    q   = word_t'(t >> 1);
    return x[W-1] ? -q : q;
  endfunction

  function automatic word_t fx_quarter(input word_t x);
    logic [W-1:0] mag;
    logic [W:0]   t;
    word_t        q;
    mag = x[W-1] ? unsigned'(-x) : unsigned'(x);
    t   = {1'b0, mag} + (W+1)'(2);
    q   = word_t'(t >> 2);
    return x[W-1] ? -q : q;
  endfunction

  function automatic word_t fx_3quarter(input word_t x);
    logic [W-1:0] mag;
    logic [W+1:0] t;
    word_t        q;
    mag = x[W-1] ? unsigned'(-x) : unsigned'(x);
    t   = {2'b00, mag} + {1'b0, mag, 1'b0} + (W+2)'(2);
    q   = word_t'(t >> 2);
    return x[W-1] ? -q : q;
  endfunction

  // coefficient registers
  word_t phi_bulk_a, phi_bulk_b, phi_kappa_base, phi_kappa_slope;
  word_t psi_bulk_a, psi_bulk_b, psi_kappa_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_bulk_a      <= '0;
      phi_bulk_b      <= '0;
      phi_kappa_base  <= '0;
      phi_kappa_slope <= '0;
      psi_bulk_a      <= '0;
      psi_bulk_b      <= '0;
      psi_kappa_gain  <= '0;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHI_BULK_A:      phi_bulk_a      <= cfg_data;
        REG_PHI_BULK_B:      phi_bulk_b      <= cfg_data;
        REG_PHI_KAPPA_BASE:  phi_kappa_base  <= cfg_data;
        REG_PHI_KAPPA_SLOPE: phi_kappa_slope <= cfg_data;
        REG_PSI_BULK_A:      psi_bulk_a      <= cfg_data;
        REG_PSI_BULK_B:      psi_bulk_b      <= cfg_data;
        REG_PSI_KAPPA_GAIN:  psi_kappa_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  word_t phi_value, psi_value, site_temperature, laplacian_phi, laplacian_psi;
  word_t g_phi [3];
  word_t g_psi [3];

  always_comb begin
    phi_value        = s_axis_tdata[0*W +: W];
    psi_value        = s_axis_tdata[1*W +: W];
    site_temperature = s_axis_tdata[2*W +: W];
    for (int k = 0; k < 3; k++) begin
      g_phi[k] = s_axis_tdata[(3+k)*W +: W];
      g_psi[k] = s_axis_tdata[(6+k)*W +: W];
    end
    laplacian_phi    = s_axis_tdata[9*W +: W];
    laplacian_psi    = s_axis_tdata[10*W +: W];
  end

  // stage flow control: a stage loads when empty or when the next one moves
  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] en;

  always_comb begin
    en[NSTAGE+1] = m_axis_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NSTAGE];

  // stage 1: first-level products
  prod_t s1_pt, s1_p2, s1_q2, s1_pl, s1_ql, s1_pa, s1_qa;
  prod_t s1_gp [NUM_PAIRS];
  prod_t s1_gq [NUM_PAIRS];
  word_t s1_phi, s1_psi, s1_lapp, s1_lapq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pt   <= fx_prod(phi_kappa_slope, site_temperature);
      s1_p2   <= fx_prod(phi_value, phi_value);
      s1_q2   <= fx_prod(psi_value, psi_value);
      s1_pl   <= fx_prod(phi_value, laplacian_phi);
      s1_ql   <= fx_prod(psi_value, laplacian_psi);
      s1_pa   <= fx_prod(phi_bulk_a, phi_value);
      s1_qa   <= fx_prod(psi_bulk_a, psi_value);
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s1_gp[k] <= fx_prod(g_phi[PAIR_A[k]], g_phi[PAIR_B[k]]);
        s1_gq[k] <= fx_prod(g_psi[PAIR_A[k]], g_psi[PAIR_B[k]]);
      end
      s1_phi  <= phi_value;
      s1_psi  <= psi_value;
      s1_lapp <= laplacian_phi;
      s1_lapq <= laplacian_psi;
    end
  end

  // stage 2: round first-level products
  word_t s2_pt, s2_p2, s2_q2, s2_pl, s2_ql, s2_pa, s2_qa;
  word_t s2_gp [NUM_PAIRS];
  word_t s2_gq [NUM_PAIRS];
  word_t s2_phi, s2_psi, s2_lapp, s2_lapq;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_pt   <= fx_round(s1_pt);
      s2_p2   <= fx_round(s1_p2);
      s2_q2   <= fx_round(s1_q2);
      s2_pl   <= fx_round(s1_pl);
      s2_ql   <= fx_round(s1_ql);
      s2_pa   <= fx_round(s1_pa);
      s2_qa   <= fx_round(s1_qa);
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s2_gp[k] <= fx_round(s1_gp[k]);
        s2_gq[k] <= fx_round(s1_gq[k]);
      end
      s2_phi  <= s1_phi;
      s2_psi  <= s1_psi;
      s2_lapp <= s1_lapp;
      s2_lapq <= s1_lapq;
    end
  end

  // stage 3: kappa of phi, partial gradient squares, powers and kq products
  word_t s3_kp, s3_gps, s3_gqs, s3_gpzz, s3_gqzz;
  word_t s3_pl, s3_ql, s3_pa, s3_qa, s3_lapp, s3_lapq;
  word_t s3_gp [NUM_PAIRS];
  prod_t s3_p3m, s3_p4m, s3_pap2m, s3_q3m, s3_q4m, s3_qaq2m;
  prod_t s3_kqgm [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_kp    <= sat_add(phi_kappa_base, s2_pt);
      s3_gps   <= sat_add(s2_gp[0], s2_gp[3]);
      s3_gqs   <= sat_add(s2_gq[0], s2_gq[3]);
      s3_gpzz  <= s2_gp[5];
      s3_gqzz  <= s2_gq[5];
      s3_p3m   <= fx_prod(s2_p2, s2_phi);
      s3_p4m   <= fx_prod(s2_p2, s2_p2);
      s3_pap2m <= fx_prod(phi_bulk_a, s2_p2);
      s3_q3m   <= fx_prod(s2_q2, s2_psi);
      s3_q4m   <= fx_prod(s2_q2, s2_q2);
      s3_qaq2m <= fx_prod(psi_bulk_a, s2_q2);
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s3_kqgm[k] <= fx_prod(psi_kappa_gain, s2_gq[k]);
        s3_gp[k]   <= s2_gp[k];
      end
      s3_pl    <= s2_pl;
      s3_ql    <= s2_ql;
      s3_pa    <= s2_pa;
      s3_qa    <= s2_qa;
      s3_lapp  <= s2_lapp;
      s3_lapq  <= s2_lapq;
    end
  end

  // stage 4: finish gradient squares, round powers, kappa times Laplacian and gradients
  word_t s4_gp2, s4_gq2, s4_p3, s4_p4, s4_pap2, s4_q3, s4_q4, s4_qaq2;
  word_t s4_kp, s4_pl, s4_ql, s4_pa, s4_qa;
  word_t s4_kqg [NUM_PAIRS];
  prod_t s4_kplm, s4_kqlm;
  prod_t s4_kpgm [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_gp2  <= sat_add(s3_gps, s3_gpzz);
      s4_gq2  <= sat_add(s3_gqs, s3_gqzz);
      s4_p3   <= fx_round(s3_p3m);
      s4_p4   <= fx_round(s3_p4m);
      s4_pap2 <= fx_round(s3_pap2m);
      s4_q3   <= fx_round(s3_q3m);
      s4_q4   <= fx_round(s3_q4m);
      s4_qaq2 <= fx_round(s3_qaq2m);
      s4_kplm <= fx_prod(s3_kp, s3_lapp);
      s4_kqlm <= fx_prod(psi_kappa_gain, s3_lapq);
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s4_kqg[k]  <= fx_round(s3_kqgm[k]);
        s4_kpgm[k] <= fx_prod(s3_kp, s3_gp[k]);
      end
      s4_kp   <= s3_kp;
      s4_pl   <= s3_pl;
      s4_ql   <= s3_ql;
      s4_pa   <= s3_pa;
      s4_qa   <= s3_qa;
    end
  end

  // stage 5: quartic and cubic coefficient products, halves
  prod_t s5_pbp3m, s5_pbp4m, s5_qbq3m, s5_qbq4m, s5_kpgp2m, s5_kqgq2m;
  word_t s5_t1, s5_t4, s5_hgp2, s5_hgq2, s5_kplap, s5_kqlap;
  word_t s5_kp, s5_pl, s5_ql, s5_pa, s5_qa;
  word_t s5_kpg [NUM_PAIRS];
  word_t s5_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pbp3m  <= fx_prod(phi_bulk_b, s4_p3);
      s5_pbp4m  <= fx_prod(phi_bulk_b, s4_p4);
      s5_qbq3m  <= fx_prod(psi_bulk_b, s4_q3);
      s5_qbq4m  <= fx_prod(psi_bulk_b, s4_q4);
      s5_kpgp2m <= fx_prod(s4_kp, s4_gp2);
      s5_kqgq2m <= fx_prod(psi_kappa_gain, s4_gq2);
      s5_t1     <= fx_half(s4_pap2);
      s5_t4     <= fx_half(s4_qaq2);
      s5_hgp2   <= fx_half(s4_gp2);
      s5_hgq2   <= fx_half(s4_gq2);
      s5_kplap  <= fx_round(s4_kplm);
      s5_kqlap  <= fx_round(s4_kqlm);
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s5_kpg[k] <= fx_round(s4_kpgm[k]);
        s5_kqg[k] <= s4_kqg[k];
      end
      s5_kp     <= s4_kp;
      s5_pl     <= s4_pl;
      s5_ql     <= s4_ql;
      s5_pa     <= s4_pa;
      s5_qa     <= s4_qa;
    end
  end

  // stage 6: round, and the gradient part of the isotropic pressure
  word_t s6_pbp3, s6_pbp4, s6_qbq3, s6_qbq4, s6_kpgp2, s6_kqgq2;
  word_t s6_dp, s6_dq, s6_t1, s6_t4, s6_kplap, s6_kqlap, s6_kp, s6_pa, s6_qa;
  word_t s6_kpg [NUM_PAIRS];
  word_t s6_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pbp3  <= fx_round(s5_pbp3m);
      s6_pbp4  <= fx_round(s5_pbp4m);
      s6_qbq3  <= fx_round(s5_qbq3m);
      s6_qbq4  <= fx_round(s5_qbq4m);
      s6_kpgp2 <= fx_round(s5_kpgp2m);
      s6_kqgq2 <= fx_round(s5_kqgq2m);
      s6_dp    <= sat_sub(s5_pl, s5_hgp2);
      s6_dq    <= sat_sub(s5_ql, s5_hgq2);
      s6_t1    <= s5_t1;
      s6_t4    <= s5_t4;
      s6_kplap <= s5_kplap;
      s6_kqlap <= s5_kqlap;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s6_kpg[k] <= s5_kpg[k];
        s6_kqg[k] <= s5_kqg[k];
      end
      s6_kp    <= s5_kp;
      s6_pa    <= s5_pa;
      s6_qa    <= s5_qa;
    end
  end

  // stage 7: constant scalings, first sums of the potentials, kappa times pressure terms
  word_t s7_t1, s7_t2, s7_t3, s7_t4, s7_t5, s7_t6, s7_u2, s7_u5;
  word_t s7_mu1p, s7_mu1q, s7_kplap, s7_kqlap;
  word_t s7_kpg [NUM_PAIRS];
  word_t s7_kqg [NUM_PAIRS];
  prod_t s7_u3m, s7_u6m;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_t1    <= s6_t1;
      s7_t2    <= fx_quarter(s6_pbp4);
      s7_t3    <= fx_half(s6_kpgp2);
      s7_t4    <= s6_t4;
      s7_t5    <= fx_quarter(s6_qbq4);
      s7_t6    <= fx_half(s6_kqgq2);
      s7_u2    <= fx_3quarter(s6_pbp4);
      s7_u5    <= fx_3quarter(s6_qbq4);
      s7_mu1p  <= sat_add(s6_pa, s6_pbp3);
      s7_mu1q  <= sat_add(s6_qa, s6_qbq3);
      s7_u3m   <= fx_prod(s6_kp, s6_dp);
      s7_u6m   <= fx_prod(psi_kappa_gain, s6_dq);
      s7_kplap <= s6_kplap;
      s7_kqlap <= s6_kqlap;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s7_kpg[k] <= s6_kpg[k];
        s7_kqg[k] <= s6_kqg[k];
      end
    end
  end

  // stage 8: potentials done, first energy and pressure sums
  word_t s8_e1, s8_p01, s8_mup, s8_muq, s8_u3, s8_u6;
  word_t s8_t3, s8_t4, s8_t5, s8_t6, s8_u5;
  word_t s8_kpg [NUM_PAIRS];
  word_t s8_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_e1  <= sat_add(s7_t1, s7_t2);
      s8_p01 <= sat_add(s7_t1, s7_u2);
      s8_mup <= sat_sub(s7_mu1p, s7_kplap);
      s8_muq <= sat_sub(s7_mu1q, s7_kqlap);
      s8_u3  <= fx_round(s7_u3m);
      s8_u6  <= fx_round(s7_u6m);
      s8_t3  <= s7_t3;
      s8_t4  <= s7_t4;
      s8_t5  <= s7_t5;
      s8_t6  <= s7_t6;
      s8_u5  <= s7_u5;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s8_kpg[k] <= s7_kpg[k];
        s8_kqg[k] <= s7_kqg[k];
      end
    end
  end

  // stages 9 to 12: left-to-right saturating sums of energy and pressure
  word_t s9_e2, s9_p02, s9_t4, s9_t5, s9_t6, s9_u5, s9_u6, s9_mup, s9_muq;
  word_t s9_kpg [NUM_PAIRS];
  word_t s9_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_e2  <= sat_add(s8_e1, s8_t3);
      s9_p02 <= sat_sub(s8_p01, s8_u3);
      s9_t4  <= s8_t4;
      s9_t5  <= s8_t5;
      s9_t6  <= s8_t6;
      s9_u5  <= s8_u5;
      s9_u6  <= s8_u6;
      s9_mup <= s8_mup;
      s9_muq <= s8_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s9_kpg[k] <= s8_kpg[k];
        s9_kqg[k] <= s8_kqg[k];
      end
    end
  end

  word_t s10_e3, s10_p03, s10_t5, s10_t6, s10_u5, s10_u6, s10_mup, s10_muq;
  word_t s10_kpg [NUM_PAIRS];
  word_t s10_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_e3  <= sat_add(s9_e2, s9_t4);
      s10_p03 <= sat_add(s9_p02, s9_t4);
      s10_t5  <= s9_t5;
      s10_t6  <= s9_t6;
      s10_u5  <= s9_u5;
      s10_u6  <= s9_u6;
      s10_mup <= s9_mup;
      s10_muq <= s9_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s10_kpg[k] <= s9_kpg[k];
        s10_kqg[k] <= s9_kqg[k];
      end
    end
  end

  word_t s11_e4, s11_p04, s11_t6, s11_u6, s11_mup, s11_muq;
  word_t s11_kpg [NUM_PAIRS];
  word_t s11_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_e4  <= sat_add(s10_e3, s10_t5);
      s11_p04 <= sat_add(s10_p03, s10_u5);
      s11_t6  <= s10_t6;
      s11_u6  <= s10_u6;
      s11_mup <= s10_mup;
      s11_muq <= s10_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s11_kpg[k] <= s10_kpg[k];
        s11_kqg[k] <= s10_kqg[k];
      end
    end
  end

  word_t s12_e, s12_p0, s12_mup, s12_muq;
  word_t s12_kpg [NUM_PAIRS];
  word_t s12_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_e   <= sat_add(s11_e4, s11_t6);
      s12_p0  <= sat_sub(s11_p04, s11_u6);
      s12_mup <= s11_mup;
      s12_muq <= s11_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        s12_kpg[k] <= s11_kpg[k];
        s12_kqg[k] <= s11_kqg[k];
      end
    end
  end

  // stage 13: diagonal entries take the pressure first; off-diagonal sums finish here
  word_t s13_e, s13_mup, s13_muq;
  word_t s13_st  [NUM_PAIRS];
  word_t s13_kqg [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[13]) begin
      s13_e   <= s12_e;
      s13_mup <= s12_mup;
      s13_muq <= s12_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        if (PAIR_A[k] == PAIR_B[k]) begin
          s13_st[k] <= sat_add(s12_p0, s12_kpg[k]);
        end else begin
          s13_st[k] <= sat_add(s12_kpg[k], s12_kqg[k]);
        end
        s13_kqg[k] <= s12_kqg[k];
      end
    end
  end

  // stage 14: output register; diagonal stress entries add the psi gradient term here
  word_t s14_e, s14_mup, s14_muq;
  word_t s14_st [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (en[14]) begin
      s14_e   <= s13_e;
      s14_mup <= s13_mup;
      s14_muq <= s13_muq;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        if (PAIR_A[k] == PAIR_B[k]) begin
          s14_st[k] <= sat_add(s13_st[k], s13_kqg[k]);
        end else begin
          s14_st[k] <= s13_st[k];
        end
      end
    end
  end

  logic [NUM_OUT_FIELDS*W-1:0] out_flat;

  assign out_flat = {s14_st[5], s14_st[4], s14_st[3], s14_st[2], s14_st[1], s14_st[0],
                     s14_muq, s14_mup, s14_e};
  assign m_axis_tdata = OUT_TW'(out_flat);

  // checks
  logic acc, dlv;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign dlv = m_axis_tvalid && m_axis_tready;

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) ==
              $past($countones(vld)) + int'($past(acc)) - int'($past(dlv))))
    else $error("pipeline occupancy does not match items in and out");

  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although output side is ready");

  a_empty_out: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled although output register is empty");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !m_axis_tready |-> !s_axis_tready)
    else $error("item taken while every stage is full and output stalled");

endmodule

// ===== test/two_field_phi4_free_energy_site_unit_test.sv =====
// Self-checking bench for the two-field phi^4 free energy site unit.
// Predicts energy, chemical potentials and stress per site in saturating Q15.16.
// Depends on phi4fe_pkg and the unit under test; needs no other files.
`timescale 1ns / 100ps

module two_field_phi4_free_energy_site_unit_test;
  import phi4fe_pkg::*;

  localparam int DW             = DATA_WIDTH_DEF;
  localparam int FB             = FRAC_BITS_DEF;
  localparam int IN_W           = ((NUM_IN_FIELDS * DW + 7) / 8) * 8;
  localparam int OUT_W          = ((NUM_OUT_FIELDS * DW + 7) / 8) * 8;
  localparam int PHASES         = 8;
  localparam int SITES_PER_PHASE = 92;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PAUSE      = 18;

  // input field positions, lowest first
  localparam int F_PHI = 0, F_PSI = 1, F_TEMP = 2, F_GPHI = 3, F_GPSI = 6;
  localparam int F_LAP_PHI = 9, F_LAP_PSI = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 3'd7;

  typedef logic signed [DW-1:0] word_t;
  typedef logic [OUT_W-1:0] result_t;

  localparam word_t WORD_ZERO = 32'sh0000_0000;
  localparam word_t WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN  = 32'sh8000_0000;
  localparam word_t WORD_LSB  = 32'sh0000_0001;
  localparam word_t FX_ONE    = 32'sh0001_0000;
  localparam word_t FX_HALF   = 32'sh0000_8000;

  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam longint SAT_MIN   = -64'sd2147483648;
  localparam longint C_HALF    = 64'sd1 <<< (FB - 1);
  localparam longint C_QUARTER = 64'sd1 <<< (FB - 2);
  localparam longint C_3QUART  = 64'sd3 <<< (FB - 2);

  class energy_scoreboard;
    longint  coeff[NUM_REGS];
    result_t site_results_due[$];
    int      errors;

    function new();
      foreach (coeff[i]) coeff[i] = 0;
      errors = 0;
    endfunction

    function void set_coeff(logic [CFG_INDEX_W-1:0] idx, word_t v);
      if (idx < NUM_REGS) coeff[idx] = v;
    endfunction

    function int pending();
      return site_results_due.size();
    endfunction

    function longint clamp(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    // round the magnitude to nearest, ties away from zero, then saturate
    function longint fx_mul(longint a, longint b);
      longint p, mag, q;
      p = a * b;
      mag = (p < 0) ? -p : p;
      q = (mag + C_HALF) >> FB;
      if (q > SAT_MAX) return (p < 0) ? SAT_MIN : SAT_MAX;
      return (p < 0) ? -q : q;
    endfunction

    function longint sat_add(longint a, longint b);
      return clamp(a + b);
    endfunction

    function longint sat_sub(longint a, longint b);
      return clamp(a - b);
    endfunction

    function result_t compute_site_energy(logic [IN_W-1:0] raw);
      longint  v[NUM_IN_FIELDS];
      longint  gp[3], gq[3], res[NUM_OUT_FIELDS];
      longint  kp, kq, pa, pb, qa, qb, p2, p3, p4, q2, q3, q4, gp2, gq2, e, p0, s;
      word_t   w;
      result_t packed_res;
      int      k;
      for (int i = 0; i < NUM_IN_FIELDS; i++) begin
        w = raw[i*DW +: DW];
        v[i] = w;
      end
      for (int i = 0; i < 3; i++) begin
        gp[i] = v[F_GPHI + i];
        gq[i] = v[F_GPSI + i];
      end
      pa = coeff[REG_PHI_BULK_A];
      pb = coeff[REG_PHI_BULK_B];
      qa = coeff[REG_PSI_BULK_A];
      qb = coeff[REG_PSI_BULK_B];
      kq = coeff[REG_PSI_KAPPA_GAIN];
      kp = sat_add(coeff[REG_PHI_KAPPA_BASE], fx_mul(coeff[REG_PHI_KAPPA_SLOPE], v[F_TEMP]));
      p2 = fx_mul(v[F_PHI], v[F_PHI]);
      p3 = fx_mul(p2, v[F_PHI]);
      p4 = fx_mul(p2, p2);
      q2 = fx_mul(v[F_PSI], v[F_PSI]);
      q3 = fx_mul(q2, v[F_PSI]);
      q4 = fx_mul(q2, q2);
      gp2 = sat_add(sat_add(fx_mul(gp[0], gp[0]), fx_mul(gp[1], gp[1])), fx_mul(gp[2], gp[2]));
      gq2 = sat_add(sat_add(fx_mul(gq[0], gq[0]), fx_mul(gq[1], gq[1])), fx_mul(gq[2], gq[2]));

      e = fx_mul(C_HALF, fx_mul(pa, p2));
      e = sat_add(e, fx_mul(C_QUARTER, fx_mul(pb, p4)));
      e = sat_add(e, fx_mul(C_HALF, fx_mul(kp, gp2)));
      e = sat_add(e, fx_mul(C_HALF, fx_mul(qa, q2)));
      e = sat_add(e, fx_mul(C_QUARTER, fx_mul(qb, q4)));
      e = sat_add(e, fx_mul(C_HALF, fx_mul(kq, gq2)));
      res[0] = e;
      res[1] = sat_sub(sat_add(fx_mul(pa, v[F_PHI]), fx_mul(pb, p3)), fx_mul(kp, v[F_LAP_PHI]));
      res[2] = sat_sub(sat_add(fx_mul(qa, v[F_PSI]), fx_mul(qb, q3)), fx_mul(kq, v[F_LAP_PSI]));

      // isotropic pressure, phi terms then psi terms
      p0 = fx_mul(C_HALF, fx_mul(pa, p2));
      p0 = sat_add(p0, fx_mul(C_3QUART, fx_mul(pb, p4)));
      p0 = sat_sub(p0, fx_mul(kp, sat_sub(fx_mul(v[F_PHI], v[F_LAP_PHI]),
                                          fx_mul(C_HALF, gp2))));
      p0 = sat_add(p0, fx_mul(C_HALF, fx_mul(qa, q2)));
      p0 = sat_add(p0, fx_mul(C_3QUART, fx_mul(qb, q4)));
      p0 = sat_sub(p0, fx_mul(kq, sat_sub(fx_mul(v[F_PSI], v[F_LAP_PSI]),
                                          fx_mul(C_HALF, gq2))));

      // upper triangle in xx, xy, xz, yy, yz, zz order
      k = 3;
      for (int a = 0; a < 3; a++) begin
        for (int b = a; b < 3; b++) begin
          s = (a == b) ? p0 : 0;
          s = sat_add(s, fx_mul(kp, fx_mul(gp[a], gp[b])));
          s = sat_add(s, fx_mul(kq, fx_mul(gq[a], gq[b])));
          res[k] = s;
          k++;
        end
      end
      packed_res = '0;
      for (int i = 0; i < NUM_OUT_FIELDS; i++) packed_res[i*DW +: DW] = res[i][DW-1:0];
      return packed_res;
    endfunction

    function string out_field_name(int i);
      case (i)
        0: return "energy_density";
        1: return "mu_phi";
        2: return "mu_psi";
        3: return "stress_xx";
        4: return "stress_xy";
        5: return "stress_xz";
        6: return "stress_yy";
        7: return "stress_yz";
        default: return "stress_zz";
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task note_site(logic [IN_W-1:0] raw);
      site_results_due.push_back(compute_site_energy(raw));
    endtask

    task check_site_result(logic [OUT_W-1:0] got);
      result_t want;
      word_t   g, x;
      if (site_results_due.size() == 0) begin
        report_mismatch("result item with no site outstanding");
        return;
      end
      want = site_results_due.pop_front();
      for (int i = 0; i < NUM_OUT_FIELDS; i++) begin
        g = got[i*DW +: DW];
        x = want[i*DW +: DW];
        if (g !== x)
          report_mismatch($sformatf("%s got %h want %h", out_field_name(i), g, x));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DW-1:0]    cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // fields from bit 0: phi_value, psi_value, site_temperature, grad_phi_x,
  // grad_phi_y, grad_phi_z, grad_psi_x, grad_psi_y, grad_psi_z,
  // laplacian_phi, laplacian_psi
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // fields from bit 0: energy_density, mu_phi, mu_psi, stress_xx, stress_xy,
  // stress_xz, stress_yy, stress_yz, stress_zz
  logic [OUT_W-1:0] m_axis_tdata;

  energy_scoreboard sb = new();
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;
  int quiet_cycles = 0;

  two_field_phi4_free_energy_site_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly small values so the arithmetic is not always pinned at the rails
  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) return word_t'($urandom);
    if (pick <= 6) return word_t'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    if (pick <= 8) return word_t'(int'($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000);
    case ($urandom_range(0, 5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ZERO;
      3: return FX_ONE;
      4: return -FX_ONE;
      default: return -WORD_LSB;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] uniform_site(word_t v);
    logic [IN_W-1:0] raw;
    raw = '0;
    for (int i = 0; i < NUM_IN_FIELDS; i++) raw[i*DW +: DW] = v;
    return raw;
  endfunction

  function automatic logic [IN_W-1:0] rand_site();
    logic [IN_W-1:0] raw;
    raw = '0;
    for (int i = 0; i < NUM_IN_FIELDS; i++) raw[i*DW +: DW] = rand_word();
    return raw;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, word_t v);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_coeff(idx, v);
  endtask

  task automatic load_all(word_t v);
    for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_INDEX_W'(r), v);
  endtask

  task automatic send_site(logic [IN_W-1:0] raw);
    int gap;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = (in_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_PAUSE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic run_directed();
    logic [IN_W-1:0] raw;
    send_site(uniform_site(WORD_ZERO));
    send_site(uniform_site(WORD_MAX));
    send_site(uniform_site(WORD_MIN));
    send_site(uniform_site(FX_ONE));
    send_site(uniform_site(-FX_ONE));
    send_site(uniform_site(WORD_LSB));
    send_site(uniform_site(-WORD_LSB));
    send_site(uniform_site(FX_HALF));
    send_site(uniform_site(-FX_HALF));
    // one field at the top rail, the rest at unity
    for (int f = 0; f < NUM_IN_FIELDS; f++) begin
      raw = uniform_site(FX_ONE);
      raw[f*DW +: DW] = WORD_MAX;
      send_site(raw);
    end
    for (int f = 0; f < NUM_IN_FIELDS; f++) raw[f*DW +: DW] = (f % 2) ? WORD_MIN : WORD_MAX;
    send_site(raw);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = (out_calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_PAUSE);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sb.note_site(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_site_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_PHI_BULK_A, -FX_ONE);
          write_reg(REG_PHI_BULK_B, FX_ONE);
          write_reg(REG_PHI_KAPPA_BASE, FX_HALF);
          write_reg(REG_PHI_KAPPA_SLOPE, 32'sh0000_2000);
          write_reg(REG_PSI_BULK_A, -FX_HALF);
          write_reg(REG_PSI_BULK_B, 32'sh0000_4000);
          write_reg(REG_PSI_KAPPA_GAIN, 32'sh0000_C000);
        end
        1: begin
          load_all(WORD_MAX);
          // unmapped index must leave every coefficient alone
          write_reg(CFG_INDEX_UNUSED, WORD_MIN);
        end
        2: load_all(WORD_MIN);
        3: load_all(WORD_ZERO);
        default: begin
          for (int r = 0; r < NUM_REGS; r++) write_reg(CFG_INDEX_W'(r), rand_word());
        end
      endcase
      cfg_wen <= 1'b0;
      if (phase == 0) run_directed();
      repeat (SITES_PER_PHASE) send_site(rand_site());
      drain();
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
